### rtl/rliu_pkg.sv
// Package for the raster line interrupt unit.
// Holds the command codes, register offsets, field widths and the line event struct.
// No dependencies.
package rliu_pkg;

  // Field widths fixed by the register map.
  localparam int unsigned CmdW  = 2;
  localparam int unsigned AddrW = 10;
  localparam int unsigned DataW = 8;
  localparam int unsigned CmpW  = 9;

  // Default raster geometry.
  localparam int unsigned DefCyclesPerLine = 63;
  localparam int unsigned DefLinesPerFrame = 312;

  // Register offsets within the chip window.
  localparam logic [AddrW-1:0] RegCmpLo   = 10'h011;
  localparam logic [AddrW-1:0] RegCmpHi   = 10'h012;
  localparam logic [AddrW-1:0] RegStatus  = 10'h019;
  localparam logic [AddrW-1:0] RegControl = 10'h01A;

  // Command codes carried by each transaction.
  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } rliu_cmd_e;

  // Line event from the raster counters: a new line started and its number.
  typedef struct packed {
    logic            new_line;
    logic [CmpW-1:0] line;
  } rliu_line_t;

endpackage

### rtl/rliu_raster.sv
// Raster beam counters: cycles within a line and lines within a frame.
// Depends on rliu_pkg for the line event struct and widths.
module rliu_raster import rliu_pkg::*; #(
  parameter int unsigned CYCLES_PER_LINE = DefCyclesPerLine,
  parameter int unsigned LINES_PER_FRAME = DefLinesPerFrame
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  output rliu_line_t line_evt_o
);

  localparam int unsigned CycW  = $clog2(CYCLES_PER_LINE);
  localparam int unsigned LineW = $clog2(LINES_PER_FRAME);

  logic [CycW-1:0]  cycle_q, cycle_d;
  logic [LineW-1:0] line_q, line_d;
  logic             wrap;

  // Next counter values; the line counter moves only when the cycle counter wraps.
  always_comb begin
    wrap    = tick_i && (cycle_q == CycW'(CYCLES_PER_LINE - 1));
    cycle_d = cycle_q;
    line_d  = line_q;
    if (tick_i) begin
      if (wrap) begin
        cycle_d = '0;
        if (line_q == LineW'(LINES_PER_FRAME - 1)) begin
          line_d = '0;
        end else begin
          line_d = line_q + LineW'(1);
        end
      end else begin
        cycle_d = cycle_q + CycW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= '0;
      line_q  <= '0;
    end else begin
      cycle_q <= cycle_d;
      line_q  <= line_d;
    end
  end

  // The event carries the number of the line that is just starting.
  assign line_evt_o.new_line = wrap;
  assign line_evt_o.line     = CmpW'(line_d);

endmodule

### rtl/raster_line_interrupt_unit_core.sv
// Top level of the raster line interrupt unit: input register, register file,
// compare logic and result register. Depends on rliu_pkg and rliu_raster.
// A transaction passes the input register and then the result register to the output.
// Throughput: one transaction per cycle unless stalled; input refills while a result waits.
// Reset: asynchronous, active low; counters, compare value, control and status clear to zero.
module raster_line_interrupt_unit_core import rliu_pkg::*; #(
  parameter int unsigned CYCLES_PER_LINE = DefCyclesPerLine,
  parameter int unsigned LINES_PER_FRAME = DefLinesPerFrame
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [AddrW-1:0] reg_addr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             irq_disabled_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] rdata_o,
  output logic             irq_pulse_o
);

  // Input register.
  logic             s1_valid_q;
  logic [CmdW-1:0]  s1_cmd_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_wdata_q;
  logic             s1_dis_q;

  // Result register.
  logic             out_valid_q;
  logic [DataW-1:0] out_rdata_q, out_rdata_d;
  logic             out_pulse_q, out_pulse_d;

  // Architectural registers.
  logic [CmpW-1:0]  cmp_q, cmp_d;
  logic [DataW-1:0] ctrl_q, ctrl_d;
  logic [DataW-1:0] stat_q, stat_d;

  logic       out_free;
  logic       advance;
  logic       tick;
  rliu_line_t line_evt;

  // Handshake: the stage moves when the result register is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign tick       = advance && (s1_cmd_q == CMD_TICK);

  rliu_raster #(
    .CYCLES_PER_LINE(CYCLES_PER_LINE),
    .LINES_PER_FRAME(LINES_PER_FRAME)
  ) u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .line_evt_o(line_evt)
  );

  // Per-transaction work: register access or the raster compare on a new line.
  always_comb begin
    cmp_d       = cmp_q;
    ctrl_d      = ctrl_q;
    stat_d      = stat_q;
    out_rdata_d = '0;
    out_pulse_d = 1'b0;
    if (advance) begin
      case (s1_cmd_q)
        CMD_TICK: begin
          if (line_evt.new_line && ctrl_q[0] && !stat_q[0] && (line_evt.line == cmp_q)) begin
            stat_d[0]   = 1'b1;
            out_pulse_d = !s1_dis_q;
          end
        end
        CMD_READ: begin
          if (s1_addr_q == RegStatus) begin
            out_rdata_d = stat_q;
          end else if (s1_addr_q == RegControl) begin
            out_rdata_d = ctrl_q;
          end
        end
        CMD_WRITE: begin
          if (s1_addr_q == RegCmpLo) begin
            cmp_d = {cmp_q[CmpW-1], s1_wdata_q};
          end else if (s1_addr_q == RegCmpHi) begin
            cmp_d = {s1_wdata_q[DataW-1], cmp_q[CmpW-2:0]};
          end else if (s1_addr_q == RegStatus) begin
            stat_d = s1_wdata_q;
          end else if (s1_addr_q == RegControl) begin
            ctrl_d = s1_wdata_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cmp_q       <= '0;
      ctrl_q      <= '0;
      stat_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      cmp_q  <= cmp_d;
      ctrl_q <= ctrl_d;
      stat_q <= stat_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q   <= cmd_i;
      s1_addr_q  <= reg_addr_i;
      s1_wdata_q <= wdata_i;
      s1_dis_q   <= irq_disabled_i;
    end
    if (advance) begin
      out_rdata_q <= out_rdata_d;
      out_pulse_q <= out_pulse_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = out_rdata_q;
  assign irq_pulse_o = out_pulse_q;

  // A waiting interrupt result always sees status bit 0 set.
  a_pulse_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pulse_q) |-> stat_q[0])
    else $error("interrupt pulse without status bit 0");

  // A new interrupt is raised only while status bit 0 is clear.
  a_pulse_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pulse_d |-> (tick && !stat_q[0] && ctrl_q[0]))
    else $error("interrupt raised with status set or control off");

  // A transaction that leaves the input register shows up as a result next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("transaction lost between stages");

endmodule
